/* hdl/vntc_pkg.sv */
// shared types and constants of the value noise terrain classifier
`timescale 1ns / 1ps

package vntc_pkg;

   // coordinate and fixed point geometry
   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 16;
   localparam int SCALE_BITS = 16;
   localparam int SEED_BITS  = 31;
   localparam int THR_BITS   = 17;
   localparam int Q_BITS     = FRAC_BITS + 1;
   localparam int POS_BITS   = COORD_BITS + SCALE_BITS;
   localparam int POLY_BITS  = FRAC_BITS + 4;
   localparam int STAGES     = 11;

   localparam logic [Q_BITS-1:0] ONE = Q_BITS'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] W7 = FRAC_BITS'((7 * (1 << FRAC_BITS) + 5) / 10);
   localparam logic [FRAC_BITS-1:0] W3 = FRAC_BITS'((1 << FRAC_BITS) - (7 * (1 << FRAC_BITS) + 5) / 10);

   // lattice hash constants
   localparam logic [31:0] HASH_MUL_Y    = 32'd57;
   localparam logic [31:0] HASH_MUL_SEED = 32'd131;
   localparam logic [31:0] HASH_C1       = 32'd15731;
   localparam logic [31:0] HASH_C2       = 32'd789221;
   localparam logic [31:0] HASH_C3       = 32'd1376312589;

   // dot hash constants, remainder by 100 through a reciprocal
   localparam logic [31:0] DOT_MUL_X   = 32'd739221;
   localparam logic [31:0] DOT_MUL_Y   = 32'd1376312589;
   localparam logic [31:0] DOT_MOD     = 32'd100;
   localparam logic [31:0] DOT_LIMIT   = 32'd5;
   localparam logic [31:0] DOT_RECIP   = 32'h51EB851F;
   localparam int          DOT_SHIFT   = 37;

   // register reset values
   localparam logic [SEED_BITS-1:0]  SEED_RESET   = SEED_BITS'(42);
   localparam logic [SCALE_BITS-1:0] SCALE_RESET  = SCALE_BITS'(1311);
   localparam logic [THR_BITS-1:0]   COAST_RESET  = THR_BITS'(27525);
   localparam logic [THR_BITS-1:0]   MEADOW_RESET = THR_BITS'(31457);
   localparam logic [THR_BITS-1:0]   FOREST_RESET = THR_BITS'(40632);

   // register map
   typedef enum logic [2:0] {
      CSR_NOISE_SEED       = 3'd0,
      CSR_COORD_SCALE      = 3'd1,
      CSR_COAST_THRESHOLD  = 3'd2,
      CSR_MEADOW_THRESHOLD = 3'd3,
      CSR_FOREST_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      BIOME_WATER  = 2'd0,
      BIOME_COAST  = 2'd1,
      BIOME_MEADOW = 2'd2,
      BIOME_FOREST = 2'd3
   } biome_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_pos;
      logic [COORD_BITS-1:0] y_pos;
   } req_payload_type;

   typedef struct packed {
      logic [Q_BITS-1:0] noise_level;
      logic [1:0]        biome;
      logic              dot_mark;
   } rsp_payload_type;

endpackage

/* hdl/value_noise_terrain_classifier_core.sv */
// top level: two-octave value noise, biome sort and dot mark, one tile per clock unless stalled
`timescale 1ns / 1ps

// Usage
//   req channel: one tile coordinate (x_pos, y_pos) per transaction, taken at a
//   rising edge with req_valid high and req_stall low.
//   rsp channel: one result per tile (noise_level, biome, dot_mark), taken at a
//   rising edge with rsp_valid high and rsp_stall low, in request order.
//   csr channel: csr_index selects seed, scale or one of three thresholds;
//   csr_ready is always high. Write only while no tile is in flight.
// Pipeline and throughput
//   one tile per cycle sustained while no result waits under rsp_stall. The
//   depth is set by the lattice hash (three chained 32-bit multiplies), then
//   two blend steps of multiply and add, then the octave weighting.
// Reset
//   synchronous, active high: the pipeline empties and the registers return
//   to seed 42, scale 1311 and thresholds 27525, 31457, 40632.
// Stall
//   while a result waits under rsp_stall the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.

module value_noise_terrain_classifier_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vntc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output vntc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int F  = vntc_pkg::FRAC_BITS;
   localparam int QB = vntc_pkg::Q_BITS;
   localparam int PB = vntc_pkg::POS_BITS;
   localparam int LB = vntc_pkg::POLY_BITS;
   localparam int NS = vntc_pkg::STAGES;

   // configuration registers
   logic [vntc_pkg::SEED_BITS-1:0]  seed_ff, seed_in;
   logic [vntc_pkg::SCALE_BITS-1:0] scale_ff, scale_in;
   logic [vntc_pkg::THR_BITS-1:0]   coast_ff, coast_in;
   logic [vntc_pkg::THR_BITS-1:0]   meadow_ff, meadow_in;
   logic [vntc_pkg::THR_BITS-1:0]   forest_ff, forest_in;

   assign csr_ready = 1'b1;

   always_comb begin
      seed_in   = seed_ff;
      scale_in  = scale_ff;
      coast_in  = coast_ff;
      meadow_in = meadow_ff;
      forest_in = forest_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vntc_pkg::CSR_NOISE_SEED:       seed_in   = csr_wdata[vntc_pkg::SEED_BITS-1:0];
            vntc_pkg::CSR_COORD_SCALE:      scale_in  = csr_wdata[vntc_pkg::SCALE_BITS-1:0];
            vntc_pkg::CSR_COAST_THRESHOLD:  coast_in  = csr_wdata[vntc_pkg::THR_BITS-1:0];
            vntc_pkg::CSR_MEADOW_THRESHOLD: meadow_in = csr_wdata[vntc_pkg::THR_BITS-1:0];
            vntc_pkg::CSR_FOREST_THRESHOLD: forest_in = csr_wdata[vntc_pkg::THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= vntc_pkg::SEED_RESET;
         scale_ff  <= vntc_pkg::SCALE_RESET;
         coast_ff  <= vntc_pkg::COAST_RESET;
         meadow_ff <= vntc_pkg::MEADOW_RESET;
         forest_ff <= vntc_pkg::FOREST_RESET;
      end else begin
         seed_ff   <= seed_in;
         scale_ff  <= scale_in;
         coast_ff  <= coast_in;
         meadow_ff <= meadow_in;
         forest_ff <= forest_in;
      end
   end

   // pipeline advance and valid bits
   logic          adv;
   logic [NS-1:0] vld_ff, vld_in;

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NS-1];

   always_comb begin
      vld_in = vld_ff;
      if (adv) begin
         vld_in = {vld_ff[NS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // first half of the lattice hash: mix and shift-xor
   function automatic logic [31:0] hash_pre(input logic [31:0] lx, input logic [31:0] ly,
                                            input logic [31:0] sd);
      logic [31:0] n;
      n = lx + ly * vntc_pkg::HASH_MUL_Y + sd * vntc_pkg::HASH_MUL_SEED;
      return (n << 13) ^ n;
   endfunction

   // stage 1: scaled positions, dot hash products
   logic [PB-1:0] s1_px_ff, s1_py_ff;
   logic [31:0]   s1_xm_ff, s1_ym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff <= PB'(req_payload.x_pos) * PB'(scale_ff);
         s1_py_ff <= PB'(req_payload.y_pos) * PB'(scale_ff);
         s1_xm_ff <= 32'(req_payload.x_pos) * vntc_pkg::DOT_MUL_X;
         s1_ym_ff <= 32'(req_payload.y_pos) * vntc_pkg::DOT_MUL_Y;
      end
   end

   // stage 2: lattice corners pre-hash, fractions and their squares, dot sum
   logic [31:0]  s2_hn_in [2][4];
   logic [F-1:0] s2_t_in  [2][2];
   logic [F-1:0] s2_sq_in [2][2];
   logic [31:0]  s2_hn_ff [2][4];
   logic [F-1:0] s2_t_ff  [2][2];
   logic [F-1:0] s2_sq_ff [2][2];
   logic [31:0]  s2_dv_ff;

   always_comb begin
      logic [PB:0]   pos_x, pos_y;
      logic [31:0]   lx, ly, sd;
      logic [2*F-1:0] sq;
      sd = 32'(seed_ff);
      for (int o = 0; o < 2; o++) begin
         pos_x = (o == 0) ? {1'b0, s1_px_ff} : {s1_px_ff, 1'b0};
         pos_y = (o == 0) ? {1'b0, s1_py_ff} : {s1_py_ff, 1'b0};
         lx = 32'(pos_x >> F);
         ly = 32'(pos_y >> F);
         s2_hn_in[o][0] = hash_pre(lx, ly, sd);
         s2_hn_in[o][1] = hash_pre(lx + 32'd1, ly, sd);
         s2_hn_in[o][2] = hash_pre(lx, ly + 32'd1, sd);
         s2_hn_in[o][3] = hash_pre(lx + 32'd1, ly + 32'd1, sd);
         s2_t_in[o][0]  = pos_x[F-1:0];
         s2_t_in[o][1]  = pos_y[F-1:0];
         for (int a = 0; a < 2; a++) begin
            sq = s2_t_in[o][a] * s2_t_in[o][a];
            s2_sq_in[o][a] = sq[2*F-1:F];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_hn_ff <= s2_hn_in;
         s2_t_ff  <= s2_t_in;
         s2_sq_ff <= s2_sq_in;
         s2_dv_ff <= s1_xm_ff + s1_ym_ff + 32'(seed_ff);
      end
   end

   // stage 3: hash square, cube of fraction and fade polynomial, dot quotient
   logic [31:0]  s3_hn_ff [2][4];
   logic [31:0]  s3_ha_ff [2][4];
   logic [F-1:0] s3_t3_ff [2][2];
   logic [LB-1:0] s3_poly_ff [2][2];
   logic [31:0]  s3_dv_ff, s3_dq_ff;
   logic [31:0]  s3_ha_in [2][4];
   logic [F-1:0] s3_t3_in [2][2];
   logic [LB-1:0] s3_poly_in [2][2];
   logic [63:0]  s3_qp;

   always_comb begin
      logic [2*F-1:0] cu;
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            s3_ha_in[o][c] = s2_hn_ff[o][c] * s2_hn_ff[o][c];
         end
         for (int a = 0; a < 2; a++) begin
            cu = s2_sq_ff[o][a] * s2_t_ff[o][a];
            s3_t3_in[o][a] = cu[2*F-1:F];
            s3_poly_in[o][a] = LB'((LB+1)'(6) * (LB+1)'(s2_sq_ff[o][a])
                               + (LB+1)'(10) * (LB+1)'(vntc_pkg::ONE)
                               - (LB+1)'(15) * (LB+1)'(s2_t_ff[o][a]));
         end
      end
      s3_qp = 64'(s2_dv_ff) * 64'(vntc_pkg::DOT_RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_hn_ff   <= s2_hn_ff;
         s3_ha_ff   <= s3_ha_in;
         s3_t3_ff   <= s3_t3_in;
         s3_poly_ff <= s3_poly_in;
         s3_dv_ff   <= s2_dv_ff;
         s3_dq_ff   <= 32'(s3_qp >> vntc_pkg::DOT_SHIFT);
      end
   end

   // stage 4: hash polynomial, fade value, dot remainder test
   logic [31:0]  s4_hn_ff [2][4];
   logic [31:0]  s4_hb_ff [2][4];
   logic [QB-1:0] s4_f_ff [2][2];
   logic         s4_dot_ff;
   logic [31:0]  s4_hb_in [2][4];
   logic [QB-1:0] s4_f_in [2][2];
   logic [31:0]  s4_rem;

   always_comb begin
      logic [F+LB-1:0] fp;
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            s4_hb_in[o][c] = s3_ha_ff[o][c] * vntc_pkg::HASH_C1 + vntc_pkg::HASH_C2;
         end
         for (int a = 0; a < 2; a++) begin
            fp = (F+LB)'(s3_t3_ff[o][a]) * (F+LB)'(s3_poly_ff[o][a]);
            s4_f_in[o][a] = QB'(fp >> F);
         end
      end
      s4_rem = s3_dv_ff - s3_dq_ff * vntc_pkg::DOT_MOD;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_hn_ff  <= s3_hn_ff;
         s4_hb_ff  <= s4_hb_in;
         s4_f_ff   <= s4_f_in;
         s4_dot_ff <= !s3_dv_ff[31] && (s4_rem < vntc_pkg::DOT_LIMIT);
      end
   end

   // stage 5: final hash multiply and corner value
   logic [QB-1:0] s5_c_ff [2][4];
   logic [QB-1:0] s5_f_ff [2][2];
   logic          s5_dot_ff;
   logic [QB-1:0] s5_c_in [2][4];

   always_comb begin
      logic [31:0] m;
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            m = (s4_hn_ff[o][c] * s4_hb_ff[o][c] + vntc_pkg::HASH_C3) & 32'h7fffffff;
            s5_c_in[o][c] = vntc_pkg::ONE - QB'(m >> (31 - F));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_c_ff   <= s5_c_in;
         s5_f_ff   <= s4_f_ff;
         s5_dot_ff <= s4_dot_ff;
      end
   end

   // stage 6: horizontal blend products
   logic [QB-1:0]   s6_a_ff   [2][2];
   logic            s6_neg_ff [2][2];
   logic [2*QB-1:0] s6_pr_ff  [2][2];
   logic [QB-1:0]   s6_fy_ff  [2];
   logic            s6_dot_ff;
   logic [QB-1:0]   s6_a_in   [2][2];
   logic            s6_neg_in [2][2];
   logic [2*QB-1:0] s6_pr_in  [2][2];

   always_comb begin
      logic [QB-1:0] ca, cb, df;
      for (int o = 0; o < 2; o++) begin
         for (int r = 0; r < 2; r++) begin
            ca = s5_c_ff[o][2*r];
            cb = s5_c_ff[o][2*r+1];
            s6_neg_in[o][r] = cb < ca;
            df = (cb < ca) ? ca - cb : cb - ca;
            s6_a_in[o][r]  = ca;
            s6_pr_in[o][r] = (2*QB)'(s5_f_ff[o][0]) * (2*QB)'(df);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_a_ff   <= s6_a_in;
         s6_neg_ff <= s6_neg_in;
         s6_pr_ff  <= s6_pr_in;
         s6_fy_ff  <= '{s5_f_ff[0][1], s5_f_ff[1][1]};
         s6_dot_ff <= s5_dot_ff;
      end
   end

   // stage 7: horizontal blend results
   logic [QB-1:0] s7_r_ff [2][2];
   logic [QB-1:0] s7_fy_ff [2];
   logic          s7_dot_ff;
   logic [QB-1:0] s7_r_in [2][2];

   always_comb begin
      logic [QB-1:0] dq;
      for (int o = 0; o < 2; o++) begin
         for (int r = 0; r < 2; r++) begin
            dq = QB'(s6_pr_ff[o][r] >> F);
            s7_r_in[o][r] = s6_neg_ff[o][r] ? s6_a_ff[o][r] - dq : s6_a_ff[o][r] + dq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_r_ff   <= s7_r_in;
         s7_fy_ff  <= s6_fy_ff;
         s7_dot_ff <= s6_dot_ff;
      end
   end

   // stage 8: vertical blend products
   logic [QB-1:0]   s8_a_ff   [2];
   logic            s8_neg_ff [2];
   logic [2*QB-1:0] s8_pr_ff  [2];
   logic            s8_dot_ff;
   logic [QB-1:0]   s8_a_in   [2];
   logic            s8_neg_in [2];
   logic [2*QB-1:0] s8_pr_in  [2];

   always_comb begin
      logic [QB-1:0] ra, rb, df;
      for (int o = 0; o < 2; o++) begin
         ra = s7_r_ff[o][0];
         rb = s7_r_ff[o][1];
         s8_neg_in[o] = rb < ra;
         df = (rb < ra) ? ra - rb : rb - ra;
         s8_a_in[o]  = ra;
         s8_pr_in[o] = (2*QB)'(s7_fy_ff[o]) * (2*QB)'(df);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_a_ff   <= s8_a_in;
         s8_neg_ff <= s8_neg_in;
         s8_pr_ff  <= s8_pr_in;
         s8_dot_ff <= s7_dot_ff;
      end
   end

   // stage 9: octave values
   logic [QB-1:0] s9_n_ff [2];
   logic          s9_dot_ff;
   logic [QB-1:0] s9_n_in [2];

   always_comb begin
      logic [QB-1:0] dq;
      for (int o = 0; o < 2; o++) begin
         dq = QB'(s8_pr_ff[o] >> F);
         s9_n_in[o] = s8_neg_ff[o] ? s8_a_ff[o] - dq : s8_a_ff[o] + dq;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_n_ff   <= s9_n_in;
         s9_dot_ff <= s8_dot_ff;
      end
   end

   // stage 10: weighted octave sum
   logic [QB-1:0]   s10_noise_ff;
   logic            s10_dot_ff;
   logic [2*QB-1:0] s10_sum;

   assign s10_sum = (2*QB)'(s9_n_ff[0]) * (2*QB)'(vntc_pkg::W7)
                  + (2*QB)'(s9_n_ff[1]) * (2*QB)'(vntc_pkg::W3);

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_noise_ff <= QB'(s10_sum >> F);
         s10_dot_ff   <= s9_dot_ff;
      end
   end

   // stage 11: biome sort and output register
   vntc_pkg::rsp_payload_type out_ff, out_in;
   vntc_pkg::biome_type       biome;

   always_comb begin
      if (32'(s10_noise_ff) < 32'(coast_ff)) begin
         biome = vntc_pkg::BIOME_WATER;
      end else if (32'(s10_noise_ff) < 32'(meadow_ff)) begin
         biome = vntc_pkg::BIOME_COAST;
      end else if (32'(s10_noise_ff) < 32'(forest_ff)) begin
         biome = vntc_pkg::BIOME_MEADOW;
      end else begin
         biome = vntc_pkg::BIOME_FOREST;
      end
      out_in.noise_level = s10_noise_ff;
      out_in.biome       = biome;
      out_in.dot_mark    = (biome != vntc_pkg::BIOME_WATER) && s10_dot_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_payload = out_ff;

   // checks
   a_water_no_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.biome == vntc_pkg::BIOME_WATER) |-> !rsp_payload.dot_mark)
      else $error("dot mark on a water tile");

   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.noise_level <= vntc_pkg::ONE))
      else $error("noise level above one");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_forest_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.biome == vntc_pkg::BIOME_FOREST)
      |-> (32'(rsp_payload.noise_level) >= 32'(forest_ff)))
      else $error("forest tile below forest threshold");

endmodule
